### hdl/assert_macros.svh
// Assertion macros used by the hit table top level.
// Depends on nothing; users must have clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define PRHT_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define PRHT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PRHT_ASSERT(label, cond, msg)
`define PRHT_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

### hdl/prht_pkg.sv
// Package for the priority rectangle hit table: sizes, request codes and
// the entry and query token types. Depends on nothing.
`default_nettype none

package prht_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);
  localparam int COORD_W     = 19;

  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_ADD   = 2'd1;
  localparam logic [1:0] REQ_HIT   = 2'd2;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] left;
    logic [15:0] top;
    logic [15:0] width;
    logic [15:0] height;
  } entry_t;

  typedef struct packed {
    logic               valid;
    logic               found;
    logic [15:0]        id;
    logic signed [COORD_W-1:0] dx;
    logic signed [COORD_W-1:0] dy;
    logic [COUNT_W-1:0] pos;
  } token_t;

endpackage

`default_nettype wire

### hdl/prht_ifs.sv
// Channel interfaces of the hit table: requests, results and the
// view_top register write. Depends on nothing.
`default_nettype none

interface prht_req_if;
  logic              valid;
  logic              ready;
  logic [1:0]        req_type;
  logic [15:0]       rect_id;
  logic [15:0]       rect_left;
  logic [15:0]       rect_top;
  logic [15:0]       rect_width;
  logic [15:0]       rect_height;
  logic signed [15:0] point_x;
  logic signed [15:0] point_y;
  logic [15:0]       scroll_offset;

  modport source (output valid, req_type, rect_id, rect_left, rect_top, rect_width,
                  rect_height, point_x, point_y, scroll_offset, input ready);
  modport sink (input valid, req_type, rect_id, rect_left, rect_top, rect_width,
                rect_height, point_x, point_y, scroll_offset, output ready);
endinterface

interface prht_res_if;
  logic        valid;
  logic        ready;
  logic        hit_found;
  logic [15:0] hit_id;
  logic        add_dropped;

  modport source (output valid, hit_found, hit_id, add_dropped, input ready);
  modport sink (input valid, hit_found, hit_id, add_dropped, output ready);
endinterface

interface prht_cfg_if;
  logic        valid;
  logic        ready;
  logic [11:0] view_top;

  modport source (output valid, view_top, input ready);
  modport sink (input valid, view_top, output ready);
endinterface

`default_nettype wire

### hdl/prht_cell.sv
// One cell of the hit table row: holds one rectangle and tests the passing
// query token against it. Depends on prht_pkg.
`default_nettype none

module prht_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              shift_en,
  input  prht_pkg::entry_t  entry_in,
  output prht_pkg::entry_t  entry_out,
  input  logic [prht_pkg::COUNT_W-1:0] count,
  input  prht_pkg::token_t  tok_in,
  output prht_pkg::token_t  tok_out
);
  import prht_pkg::*;

  entry_t ent;
  token_t tok;
  coord_t l_edge;
  coord_t t_edge;
  coord_t r_edge;
  coord_t b_edge;
  logic   live;
  logic   hit;

  assign l_edge = coord_t'(ent.left);
  assign t_edge = coord_t'(ent.top);
  assign r_edge = l_edge + coord_t'(ent.width);
  assign b_edge = t_edge + coord_t'(ent.height);
  assign live   = tok_in.pos < count;
  assign hit    = live && (tok_in.dx >= l_edge) && (tok_in.dx < r_edge) &&
                  (tok_in.dy >= t_edge) && (tok_in.dy < b_edge);

  always_ff @(posedge clk) begin
    if (shift_en) begin
      ent <= entry_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok.valid <= 1'b0;
    end else begin
      tok.valid <= tok_in.valid;
      tok.found <= tok_in.found | hit;
      tok.id    <= (hit && !tok_in.found) ? ent.id : tok_in.id;
      tok.dx    <= tok_in.dx;
      tok.dy    <= tok_in.dy;
      tok.pos   <= tok_in.pos + COUNT_W'(1);
    end
  end

  assign entry_out = ent;
  assign tok_out   = tok;

endmodule

`default_nettype wire

### hdl/prht_chain.sv
// The row of hit table cells, newest rectangle in the first cell.
// Depends on prht_pkg and prht_cell.
`default_nettype none

module prht_chain (
  input  logic              clk,
  input  logic              rst,
  input  logic              shift_en,
  input  prht_pkg::entry_t  new_entry,
  input  logic [prht_pkg::COUNT_W-1:0] count,
  input  prht_pkg::token_t  head,
  output prht_pkg::token_t  tail
);
  import prht_pkg::*;

  entry_t ent [TABLE_DEPTH];
  token_t tok [TABLE_DEPTH+1];

  assign ent[0] = new_entry;
  assign tok[0] = head;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    if (i == TABLE_DEPTH - 1) begin : g_last
      prht_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .shift_en  (shift_en),
        .entry_in  (ent[i]),
        .entry_out (),
        .count     (count),
        .tok_in    (tok[i]),
        .tok_out   (tok[i+1])
      );
    end else begin : g_mid
      prht_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .shift_en  (shift_en),
        .entry_in  (ent[i]),
        .entry_out (ent[i+1]),
        .count     (count),
        .tok_in    (tok[i]),
        .tok_out   (tok[i+1])
      );
    end
  end

  assign tail = tok[TABLE_DEPTH];

endmodule

`default_nettype wire

### hdl/priority_rect_hit_table_unit.sv
// Priority rectangle hit table, top level: request control, the
// view_top register and the result register.
// Depends on prht_pkg, prht_ifs, prht_chain and assert_macros.svh.
//
// The table is a row of TABLE_DEPTH cells, one rectangle each, newest
// first; an add shifts every rectangle one cell along unless the table is
// full, when it is dropped, and a clear just resets the fill count. Every
// request but a hit test loads the result register at the edge of its
// transaction, so its result can be taken in the following cycle. A hit test
// sends a query token down the row, one cell per cycle, and the first live
// cell that contains the point decides the result, which is loaded as the
// token leaves the last cell. One request is in work at a time; the next is
// taken once the result register is empty or being emptied. The view_top
// register should only be written while no request is in work.
`default_nettype none
`include "assert_macros.svh"

module priority_rect_hit_table_unit (
  input  logic        clk,
  input  logic        rst,
  prht_req_if.sink    req,
  prht_res_if.source  res,
  prht_cfg_if.sink    cfg
);
  import prht_pkg::*;

  typedef enum logic {ST_IDLE, ST_SCAN} state_t;

  state_t             state;
  logic [COUNT_W-1:0] count;
  logic [11:0]        view_top;
  token_t             launch;
  token_t             tail;
  entry_t             new_entry;
  logic               req_acc;
  logic               hit_acc;
  logic               add_acc;
  logic               res_load;
  logic               full;
  logic               shift_en;
  coord_t             qx;
  coord_t             qy;

  assign cfg.ready = 1'b1;
  assign req.ready = (state == ST_IDLE) && (!res.valid || res.ready);
  assign req_acc   = req.valid && req.ready;
  assign hit_acc   = req_acc && (req.req_type == REQ_HIT);
  assign add_acc   = req_acc && (req.req_type == REQ_ADD);
  assign res_load  = (req_acc && (req.req_type != REQ_HIT)) ||
                     ((state == ST_SCAN) && tail.valid);
  assign full      = count >= COUNT_W'(TABLE_DEPTH);
  assign shift_en  = add_acc && !full;

  assign new_entry = '{id: req.rect_id, left: req.rect_left, top: req.rect_top,
                       width: req.rect_width, height: req.rect_height};

  assign qx = coord_t'(req.point_x);
  assign qy = coord_t'(req.point_y) - coord_t'(view_top) +
              coord_t'(req.scroll_offset);

  prht_chain u_chain (
    .clk       (clk),
    .rst       (rst),
    .shift_en  (shift_en),
    .new_entry (new_entry),
    .count     (count),
    .head      (launch),
    .tail      (tail)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      count        <= '0;
      view_top     <= '0;
      launch.valid <= 1'b0;
      res.valid    <= 1'b0;
    end else begin
      launch.valid <= hit_acc;
      if (cfg.valid && cfg.ready) begin
        view_top <= cfg.view_top;
      end
      if (res_load) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req_acc) begin
            case (req.req_type)
              REQ_CLEAR: begin
                count           <= '0;
                res.hit_found   <= 1'b0;
                res.hit_id      <= '0;
                res.add_dropped <= 1'b0;
              end
              REQ_ADD: begin
                if (!full) begin
                  count <= count + COUNT_W'(1);
                end
                res.hit_found   <= 1'b0;
                res.hit_id      <= '0;
                res.add_dropped <= full;
              end
              REQ_HIT: begin
                launch.found <= 1'b0;
                launch.id    <= '0;
                launch.dx    <= qx;
                launch.dy    <= qy;
                launch.pos   <= '0;
                state        <= ST_SCAN;
              end
              default: begin
                res.hit_found   <= 1'b0;
                res.hit_id      <= '0;
                res.add_dropped <= 1'b0;
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (tail.valid) begin
            res.hit_found   <= tail.found;
            res.hit_id      <= tail.id;
            res.add_dropped <= 1'b0;
            state           <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `PRHT_ASSERT(a_count_range, count <= COUNT_W'(TABLE_DEPTH), "fill count beyond depth")
  `PRHT_ASSERT(a_tail_in_scan, !tail.valid || (state == ST_SCAN), "token out of a scan")
  `PRHT_ASSERT_NEXT(a_hit_starts_scan, hit_acc, (state == ST_SCAN) && !res.valid, "no scan")
  `PRHT_ASSERT_NEXT(a_full_add_keeps, add_acc && full, $stable(count) && res.add_dropped, "drop")

endmodule

`default_nettype wire

### tb/sv/tb_priority_rect_hit_table_unit.sv
`timescale 1ns / 100ps
// Testbench for priority_rect_hit_table_unit: clear, add, hit-test and unused-code
// transactions are checked field by field against a behavioural copy of the table.
// Depends on prht_pkg, the prht channel interfaces and the hit table RTL.

module tb_priority_rect_hit_table_unit;
  import prht_pkg::*;

  localparam logic [1:0] REQ_NONE = 2'd3;
  localparam int QUIET_LIMIT = 6000;
  localparam int LONG_HOLD = 1500;
  localparam int PHASE_ITEMS = 220;
  localparam int PHASES = 6;

  typedef struct packed {
    logic [1:0]         kind;
    logic [15:0]        id;
    logic [15:0]        left;
    logic [15:0]        top;
    logic [15:0]        width;
    logic [15:0]        height;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic [15:0]        scroll;
  } rect_req_t;

  typedef struct packed {
    logic        found;
    logic [15:0] id;
    logic        dropped;
  } hit_reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  prht_req_if req ();
  prht_res_if res ();
  prht_cfg_if cfg ();

  priority_rect_hit_table_unit u_top (
    .clk(clk),
    .rst(rst),
    .req(req),
    .res(res),
    .cfg(cfg)
  );

  rect_req_t  pending_reqs[$];
  hit_reply_t replies_due[$];
  entry_t     rect_cells[TABLE_DEPTH];
  int         cell_count = 0;
  logic [11:0] top_row = 12'd0;
  rect_req_t  taken_req;
  hit_reply_t due;
  bit         req_taken = 1'b0;
  int         mismatches = 0;
  int         replies_seen = 0;
  int         quiet_cycles = 0;
  int         burst_left = 0;
  int         gap_left = 0;
  int         hold_left = 0;
  int         holds_done = 0;
  int         pattern_left = 0;
  int         pattern_mode = 0;

  always #5 clk = ~clk;

  function automatic hit_reply_t apply_table_request(input rect_req_t r);
    hit_reply_t rep;
    int dx, dy, l, t, k;
    rep = '0;
    case (r.kind)
      REQ_CLEAR: cell_count = 0;
      REQ_ADD: begin
        if (cell_count >= TABLE_DEPTH) begin
          rep.dropped = 1'b1;
        end else begin
          rect_cells[cell_count] = {r.id, r.left, r.top, r.width, r.height};
          cell_count++;
        end
      end
      REQ_HIT: begin
        dx = int'(r.px);
        dy = int'(r.py);
        dy = dy - int'(top_row) + int'(r.scroll);
        for (k = cell_count - 1; k >= 0 && !rep.found; k--) begin
          l = int'(rect_cells[k].left);
          t = int'(rect_cells[k].top);
          if (dx >= l && dx < l + int'(rect_cells[k].width) &&
              dy >= t && dy < t + int'(rect_cells[k].height)) begin
            rep.found = 1'b1;
            rep.id = rect_cells[k].id;
          end
        end
      end
      default: ;
    endcase
    return rep;
  endfunction

  function automatic rect_req_t random_request();
    rect_req_t r;
    r.kind = 2'($urandom_range(0, 3));
    r.id = 16'($urandom);
    r.left = 16'($urandom);
    r.top = 16'($urandom);
    r.width = 16'($urandom);
    r.height = 16'($urandom);
    r.px = 16'($urandom);
    r.py = 16'($urandom);
    r.scroll = 16'($urandom);
    return r;
  endfunction

  function automatic rect_req_t add_request(input logic [15:0] id, l, t, w, h);
    rect_req_t r;
    r = random_request();
    r.kind = REQ_ADD;
    r.id = id;
    r.left = l;
    r.top = t;
    r.width = w;
    r.height = h;
    return r;
  endfunction

  function automatic rect_req_t hit_request(input logic signed [15:0] px, py,
                                            input logic [15:0] scroll);
    rect_req_t r;
    r = random_request();
    r.kind = REQ_HIT;
    r.px = px;
    r.py = py;
    r.scroll = scroll;
    return r;
  endfunction

  function automatic int pick_near(input int base, input int size);
    case ($urandom_range(0, 5))
      0: return base;
      1: return base + size - 1;
      2: return base + size;
      3: return base - 1;
      default: return (size > 0) ? base + $urandom_range(size - 1, 0) : base;
    endcase
  endfunction

  task automatic compare_field(input string name, input logic [15:0] want, got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic wait_table_idle();
    while (pending_reqs.size() != 0 || replies_due.size() != 0) @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else if (!(req.valid && !req_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        req.valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        req.req_type <= pending_reqs[0].kind;
        req.rect_id <= pending_reqs[0].id;
        req.rect_left <= pending_reqs[0].left;
        req.rect_top <= pending_reqs[0].top;
        req.rect_width <= pending_reqs[0].width;
        req.rect_height <= pending_reqs[0].height;
        req.point_x <= pending_reqs[0].px;
        req.point_y <= pending_reqs[0].py;
        req.scroll_offset <= pending_reqs[0].scroll;
        req.valid <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          case ($urandom_range(0, 9))
            0, 1, 2: gap_left = 0;
            3: gap_left = $urandom_range(30, 90);
            default: gap_left = $urandom_range(1, 8);
          endcase
        end
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      res.ready <= 1'b0;
    end else if (holds_done < 2 && replies_seen >= (holds_done == 0 ? 30 : 900)) begin
      hold_left = LONG_HOLD;
      holds_done++;
      res.ready <= 1'b0;
    end else begin
      if (pattern_left == 0) begin
        pattern_mode = $urandom_range(0, 3);
        pattern_left = $urandom_range(16, 160);
      end
      pattern_left--;
      case (pattern_mode)
        0: res.ready <= 1'b1;
        1: res.ready <= ($urandom_range(0, 3) != 0);
        2: res.ready <= ($urandom_range(0, 3) == 0);
        default: res.ready <= pattern_left[0];
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      req_taken = 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        replies_seen++;
        if (replies_due.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual found %b id %h dropped %b",
                   $time, res.hit_found, res.hit_id, res.add_dropped);
          mismatches++;
        end else begin
          due = replies_due.pop_front();
          compare_field("hit_found", 16'(due.found), 16'(res.hit_found));
          compare_field("hit_id", due.id, res.hit_id);
          compare_field("add_dropped", 16'(due.dropped), 16'(res.add_dropped));
        end
      end
      if (cfg.valid && cfg.ready) top_row = cfg.view_top;
      req_taken = req.valid && req.ready;
      if (req_taken) begin
        taken_req = pending_reqs.pop_front();
        replies_due.push_back(apply_table_request(taken_req));
      end
      if ((res.valid && res.ready) || (cfg.valid && cfg.ready) || req_taken) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t ns: no transaction for %0d cycles", $time, QUIET_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    rect_req_t r;
    entry_t e, aim;
    entry_t scene_rects[$];
    logic [11:0] new_top;
    int phase, phase_count, n_adds, n_hits, i, tx, ty, lo, hi, y_base;
    bit fresh;

    req.valid = 1'b0;
    req.req_type = REQ_CLEAR;
    req.rect_id = '0;
    req.rect_left = '0;
    req.rect_top = '0;
    req.rect_width = '0;
    req.rect_height = '0;
    req.point_x = '0;
    req.point_y = '0;
    req.scroll_offset = '0;
    res.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.view_top = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    pending_reqs.push_back(hit_request(0, 0, 0));
    pending_reqs.push_back(add_request(16'h1234, 10, 20, 5, 3));
    pending_reqs.push_back(hit_request(10, 20, 0));
    pending_reqs.push_back(hit_request(14, 22, 0));
    pending_reqs.push_back(hit_request(15, 20, 0));
    pending_reqs.push_back(hit_request(10, 23, 0));
    pending_reqs.push_back(hit_request(9, 20, 0));
    pending_reqs.push_back(add_request(16'hBEEF, 12, 20, 10, 10));
    pending_reqs.push_back(hit_request(13, 21, 0));
    pending_reqs.push_back(hit_request(11, 21, 0));
    pending_reqs.push_back(add_request(16'hFFFF, 0, 0, 0, 16'hFFFF));
    pending_reqs.push_back(add_request(16'h0001, 0, 0, 16'hFFFF, 0));
    pending_reqs.push_back(hit_request(0, 0, 0));
    pending_reqs.push_back(add_request(16'h8000, 0, 0, 16'hFFFF, 16'hFFFF));
    pending_reqs.push_back(hit_request(-32768, 0, 0));
    pending_reqs.push_back(hit_request(32767, -32768, 16'hFFFF));
    pending_reqs.push_back(hit_request(0, -32768, 0));
    r = random_request();
    r.kind = REQ_NONE;
    pending_reqs.push_back(r);
    pending_reqs.push_back(hit_request(13, 21, 0));
    r = random_request();
    r.kind = REQ_CLEAR;
    pending_reqs.push_back(r);
    pending_reqs.push_back(hit_request(13, 21, 0));
    pending_reqs.push_back(add_request(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    pending_reqs.push_back(hit_request(32767, 32767, 16'hFFFF));
    pending_reqs.push_back(add_request(16'h0000, 0, 0, 1, 1));
    pending_reqs.push_back(hit_request(0, 0, 0));

    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: new_top = 12'hFFF;
        1: new_top = 12'h000;
        3: new_top = 12'h001;
        default: new_top = 12'($urandom);
      endcase
      wait_table_idle();
      @(negedge clk);
      cfg.view_top <= new_top;
      cfg.valid <= 1'b1;
      @(posedge clk);
      while (!cfg.ready) @(posedge clk);
      @(negedge clk);
      cfg.valid <= 1'b0;

      phase_count = 0;
      fresh = 1'b1;
      while (phase_count < PHASE_ITEMS) begin
        if (fresh || $urandom_range(0, 4) != 0) begin
          r = random_request();
          r.kind = REQ_CLEAR;
          pending_reqs.push_back(r);
          scene_rects.delete();
          phase_count++;
        end
        if (fresh && phase % 2 == 0) n_adds = $urandom_range(258, 300);
        else if ($urandom_range(0, 19) < 3) n_adds = $urandom_range(200, 290);
        else n_adds = $urandom_range(1, 24);
        fresh = 1'b0;
        y_base = $urandom_range(0, 64000);
        for (i = 0; i < n_adds; i++) begin
          e.id = 16'($urandom);
          if ($urandom_range(0, 9) == 0) begin
            e.left = 16'($urandom);
            e.top = 16'($urandom);
            e.width = 16'($urandom);
            e.height = 16'($urandom);
          end else begin
            e.left = 16'($urandom_range(0, 1200));
            e.top = 16'(y_base + $urandom_range(0, 1200));
            e.width = ($urandom_range(0, 19) == 0) ? 16'd0 : 16'($urandom_range(1, 400));
            e.height = ($urandom_range(0, 19) == 0) ? 16'd0 : 16'($urandom_range(1, 400));
          end
          pending_reqs.push_back(add_request(e.id, e.left, e.top, e.width, e.height));
          scene_rects.push_back(e);
          phase_count++;
          if ($urandom_range(0, 19) == 0) begin
            pending_reqs.push_back(random_request());
            phase_count++;
          end
        end
        n_hits = $urandom_range(1, 16);
        for (i = 0; i < n_hits; i++) begin
          r = hit_request(16'($urandom), 16'($urandom), 16'($urandom));
          if (scene_rects.size() != 0 && $urandom_range(0, 4) != 0) begin
            aim = scene_rects[$urandom_range(scene_rects.size() - 1, 0)];
            tx = pick_near(int'(aim.left), int'(aim.width));
            ty = pick_near(int'(aim.top), int'(aim.height));
            if (tx >= -32768 && tx <= 32767) r.px = 16'(tx);
            lo = ty + int'(new_top) - 32767;
            hi = ty + int'(new_top) + 32768;
            if (lo < 0) lo = 0;
            if (hi > 65535) hi = 65535;
            if (lo <= hi) begin
              r.scroll = 16'($urandom_range(hi, lo));
              r.py = 16'(ty + int'(new_top) - int'(r.scroll));
            end
          end
          pending_reqs.push_back(r);
          phase_count++;
          if ($urandom_range(0, 9) == 0) begin
            e.id = 16'($urandom);
            e.left = 16'($urandom_range(0, 1200));
            e.top = 16'(y_base + $urandom_range(0, 1200));
            e.width = 16'($urandom_range(1, 400));
            e.height = 16'($urandom_range(1, 400));
            pending_reqs.push_back(add_request(e.id, e.left, e.top, e.width, e.height));
            scene_rects.push_back(e);
            phase_count++;
          end
        end
      end
    end

    wait_table_idle();
    repeat (TABLE_DEPTH + 16) @(negedge clk);
    if (mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

### priority_rect_hit_table_unit.f
+incdir+hdl
hdl/prht_pkg.sv
hdl/prht_ifs.sv
hdl/prht_cell.sv
hdl/prht_chain.sv
hdl/priority_rect_hit_table_unit.sv
tb/sv/tb_priority_rect_hit_table_unit.sv
